// ----- sv/uv_sphere_vertex_and_quad_gen_macros.svh -----
// Assertion macros for the UV sphere vertex and quad generator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef UV_SPHERE_VERTEX_AND_QUAD_GEN_MACROS_SVH
`define UV_SPHERE_VERTEX_AND_QUAD_GEN_MACROS_SVH
`ifndef SYNTHESIS
`define USG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define USG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);
`else
`define USG_ASSERT(lbl, prop, msg)
`define USG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- sv/usg_pkg.sv -----
// Shared types, constants and the arctangent table of the sphere generator.
// No dependencies.
package usg_pkg;

    localparam int DIV_STEPS    = 17;
    localparam int CORDIC_STEPS = 24;

    localparam logic [1:0] REG_SLICES = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;

    typedef struct packed {
        logic [7:0] st;
        logic [7:0] sl;
    } t_pt;

    typedef struct packed {
        t_pt         pt;
        logic [25:0] ru;
        logic [25:0] rv;
        logic [25:0] rp;
        logic [16:0] qu;
        logic [16:0] qv;
        logic [16:0] qp;
    } t_div;

    typedef struct packed {
        t_pt                pt;
        logic [16:0]        qu;
        logic [16:0]        qv;
        logic [1:0]         qa;
        logic [1:0]         qp;
        logic signed [32:0] xa;
        logic signed [32:0] ya;
        logic signed [32:0] za;
        logic signed [32:0] xp;
        logic signed [32:0] yp;
        logic signed [32:0] zp;
    } t_cor;

    function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
        logic signed [32:0] r;
        case (i)
            5'd0:    r = 33'sd843314856;
            5'd1:    r = 33'sd497837829;
            5'd2:    r = 33'sd263043836;
            5'd3:    r = 33'sd133525158;
            5'd4:    r = 33'sd67021686;
            5'd5:    r = 33'sd33543515;
            5'd6:    r = 33'sd16775850;
            5'd7:    r = 33'sd8388437;
            5'd8:    r = 33'sd4194282;
            5'd9:    r = 33'sd2097149;
            5'd10:   r = 33'sd1048575;
            5'd11:   r = 33'sd524287;
            5'd12:   r = 33'sd262143;
            5'd13:   r = 33'sd131071;
            5'd14:   r = 33'sd65535;
            5'd15:   r = 33'sd32767;
            5'd16:   r = 33'sd16383;
            5'd17:   r = 33'sd8191;
            5'd18:   r = 33'sd4095;
            5'd19:   r = 33'sd2047;
            5'd20:   r = 33'sd1023;
            5'd21:   r = 33'sd511;
            5'd22:   r = 33'sd255;
            5'd23:   r = 33'sd127;
            default: r = 33'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/usg_div_cell.sv -----
// One restoring division step for the u, v and polar phase quotients.
// Depends on usg_pkg.
module usg_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_step,
    input  logic [8:0]         i_dv_u,
    input  logic [8:0]         i_dv_v,
    input  logic               i_valid,
    input  usg_pkg::t_div      i_d,
    input  logic               i_down_en,
    output logic               o_en,
    output logic               o_valid,
    output usg_pkg::t_div      o_d
);
    logic          r_valid;
    usg_pkg::t_div r_d;
    usg_pkg::t_div n_d;
    logic [25:0]   du;
    logic [25:0]   dv;
    logic [16:0]   bit_m;

    assign o_en = !r_valid || i_down_en;

    always_comb begin
        du    = {17'd0, i_dv_u} << i_step;
        dv    = {17'd0, i_dv_v} << i_step;
        bit_m = 17'd1 << i_step;
        n_d   = i_d;
        if (i_d.ru >= du) begin
            n_d.ru = i_d.ru - du;
            n_d.qu = i_d.qu | bit_m;
        end
        if (i_d.rv >= dv) begin
            n_d.rv = i_d.rv - dv;
            n_d.qv = i_d.qv | bit_m;
        end
        if (i_d.rp >= dv) begin
            n_d.rp = i_d.rp - dv;
            n_d.qp = i_d.qp | bit_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
        if (o_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule

// ----- sv/usg_cordic_cell.sv -----
// One CORDIC rotation step applied to the azimuth and polar angles.
// Depends on usg_pkg.
module usg_cordic_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_step,
    input  logic               i_valid,
    input  usg_pkg::t_cor      i_d,
    input  logic               i_down_en,
    output logic               o_en,
    output logic               o_valid,
    output usg_pkg::t_cor      o_d
);
    logic               r_valid;
    usg_pkg::t_cor      r_d;
    usg_pkg::t_cor      n_d;
    logic signed [32:0] ang;

    assign o_en = !r_valid || i_down_en;

    always_comb begin
        ang = usg_pkg::atan_q30(i_step);
        n_d = i_d;
        if (!i_d.za[32]) begin
            n_d.xa = i_d.xa - (i_d.ya >>> i_step);
            n_d.ya = i_d.ya + (i_d.xa >>> i_step);
            n_d.za = i_d.za - ang;
        end else begin
            n_d.xa = i_d.xa + (i_d.ya >>> i_step);
            n_d.ya = i_d.ya - (i_d.xa >>> i_step);
            n_d.za = i_d.za + ang;
        end
        if (!i_d.zp[32]) begin
            n_d.xp = i_d.xp - (i_d.yp >>> i_step);
            n_d.yp = i_d.yp + (i_d.xp >>> i_step);
            n_d.zp = i_d.zp - ang;
        end else begin
            n_d.xp = i_d.xp + (i_d.yp >>> i_step);
            n_d.yp = i_d.yp - (i_d.xp >>> i_step);
            n_d.zp = i_d.zp + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
        if (o_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule

// ----- sv/usg_post.sv -----
// Quadrant fold, normal and position products, rounding, quad indices and
// the output register. Depends on usg_pkg.
module usg_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_slices,
    input  logic [7:0]          i_stacks,
    input  logic [15:0]         i_radius,
    input  logic                i_valid,
    input  usg_pkg::t_cor       i_d,
    input  logic                i_out_stall,
    output logic                o_en,
    output logic                o_out_valid,
    output logic signed [16:0]  o_pos_x,
    output logic signed [16:0]  o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [16:0]         o_tex_u,
    output logic [16:0]         o_tex_v,
    output logic [15:0]         o_quad_first,
    output logic [15:0]         o_quad_second,
    output logic                o_quad_valid,
    output logic                o_point_valid
);
    logic en_a, en_b, en_c;
    logic r_va, r_vb, r_vc;

    // stage A: fold quadrant, form sin(p)*cos(a) and sin(p)*sin(a)
    logic signed [32:0] ca, sa, cp, sp;
    logic signed [65:0] r_pc, r_ps;
    logic signed [32:0] r_cp_a;
    usg_pkg::t_pt       r_pt_a, r_pt_b;
    logic [16:0]        r_qu_a, r_qv_a, r_qu_b, r_qv_b;

    // stage B: normal in Q30, rounded normal, radius products
    logic signed [65:0] t_x, t_z;
    logic signed [33:0] n_k [3];
    logic signed [33:0] nr;
    logic signed [15:0] nn [3];
    logic signed [49:0] r_rp [3];
    logic signed [15:0] r_nn [3];

    // stage C
    logic signed [49:0] pr;
    logic signed [16:0] pp [3];
    logic               pv, qv;
    logic [16:0]        first_w;

    assign en_c = !r_vc || !i_out_stall;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;
    assign o_en = en_a;

    always_comb begin
        case (i_d.qa)
            2'd0:    begin ca = i_d.xa;  sa = i_d.ya;  end
            2'd1:    begin ca = -i_d.ya; sa = i_d.xa;  end
            2'd2:    begin ca = -i_d.xa; sa = -i_d.ya; end
            default: begin ca = i_d.ya;  sa = -i_d.xa; end
        endcase
        case (i_d.qp)
            2'd0:    begin cp = i_d.xp;  sp = i_d.yp;  end
            2'd1:    begin cp = -i_d.yp; sp = i_d.xp;  end
            2'd2:    begin cp = -i_d.xp; sp = -i_d.yp; end
            default: begin cp = i_d.yp;  sp = -i_d.xp; end
        endcase
    end

    always_comb begin
        t_x    = (r_pc + 66'sd536870912) >>> 30;
        t_z    = (r_ps + 66'sd536870912) >>> 30;
        n_k[0] = t_x[33:0];
        n_k[1] = {r_cp_a[32], r_cp_a};
        n_k[2] = t_z[33:0];
        for (int k = 0; k < 3; k++) begin
            nr = (n_k[k] + 34'sd16384) >>> 15;
            if (nr > 34'sd32767) begin
                nn[k] = 16'sd32767;
            end else if (nr < -34'sd32767) begin
                nn[k] = -16'sd32767;
            end else begin
                nn[k] = nr[15:0];
            end
            if (i_radius == 16'd0) begin
                nn[k] = 16'sd0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pr = (r_rp[k] + 50'sd536870912) >>> 30;
            if (pr > 50'sd65535) begin
                pp[k] = 17'sd65535;
            end else if (pr < -50'sd65535) begin
                pp[k] = -17'sd65535;
            end else begin
                pp[k] = pr[16:0];
            end
        end
        pv = (i_slices != 8'd0) && (i_stacks != 8'd0)
            && (r_pt_b.st <= i_stacks) && (r_pt_b.sl <= i_slices);
        qv = pv && (r_pt_b.st < i_stacks) && (r_pt_b.sl < i_slices);
        first_w = 17'(r_pt_b.st * ({1'b0, i_slices} + 9'd1)) + {9'd0, r_pt_b.sl};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
        end
        if (en_a) begin
            r_pc   <= sp * ca;
            r_ps   <= sp * sa;
            r_cp_a <= cp;
            r_pt_a <= i_d.pt;
            r_qu_a <= i_d.qu;
            r_qv_a <= i_d.qv;
        end
        if (en_b) begin
            for (int k = 0; k < 3; k++) begin
                r_rp[k] <= $signed({1'b0, i_radius}) * n_k[k];
                r_nn[k] <= nn[k];
            end
            r_pt_b <= r_pt_a;
            r_qu_b <= r_qu_a;
            r_qv_b <= r_qv_a;
        end
        if (en_c) begin
            o_pos_x       <= pv ? pp[0] : 17'sd0;
            o_pos_y       <= pv ? pp[1] : 17'sd0;
            o_pos_z       <= pv ? pp[2] : 17'sd0;
            o_norm_x      <= pv ? r_nn[0] : 16'sd0;
            o_norm_y      <= pv ? r_nn[1] : 16'sd0;
            o_norm_z      <= pv ? r_nn[2] : 16'sd0;
            o_tex_u       <= pv ? r_qu_b : 17'd0;
            o_tex_v       <= pv ? r_qv_b : 17'd0;
            o_quad_first  <= qv ? first_w[15:0] : 16'd0;
            o_quad_second <= qv ? first_w[15:0] + {8'd0, i_slices} + 16'd1 : 16'd0;
            o_quad_valid  <= qv;
            o_point_valid <= pv;
        end
    end

    assign o_out_valid = r_vc;
endmodule

// ----- sv/uv_sphere_vertex_and_quad_gen.sv -----
// UV sphere vertex and quad generator, top level.
// Pipeline: 17 divide cells, phase stage, 24 CORDIC cells, 3 output
// stages. Throughput: one item per cycle while i_out_stall is low, set by
// the cell chain, every stage of which takes a new item each cycle unless stalled.
// Reset (synchronous, active low) empties the pipeline and restores
// slice_count = 16, stack_count = 16, sphere_radius = 256.
`include "uv_sphere_vertex_and_quad_gen_macros.svh"
module uv_sphere_vertex_and_quad_gen (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_stack_index,
    input  logic [7:0]          i_slice_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [16:0]  o_pos_x,
    output logic signed [16:0]  o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [16:0]         o_tex_u,
    output logic [16:0]         o_tex_v,
    output logic [15:0]         o_quad_first,
    output logic [15:0]         o_quad_second,
    output logic                o_quad_valid,
    output logic                o_point_valid
);
    // Configuration registers; the user must write them only while no item
    // is in flight (not enforced here), so every stage may read them directly.
    logic [7:0]  r_slices;
    logic [7:0]  r_stacks;
    logic [15:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slices <= 8'd16;
            r_stacks <= 8'd16;
            r_radius <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usg_pkg::REG_SLICES: r_slices <= i_cfg_data[7:0];
                usg_pkg::REG_STACKS: r_stacks <= i_cfg_data[7:0];
                usg_pkg::REG_RADIUS: r_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Divide chain: quotient bits from MSB down, one per cell.
    // u  = round(sl*2^17 / (2*slices)), also the azimuth phase
    // v  = round(st*2^17 / (2*stacks))
    // pp = round(st*2^16 / (2*stacks)), the polar phase
    usg_pkg::t_div div_d [0:usg_pkg::DIV_STEPS];
    logic          div_v [0:usg_pkg::DIV_STEPS];
    logic          div_en [0:usg_pkg::DIV_STEPS-1];
    logic          prep_en;
    logic [8:0]    dv_u, dv_v;

    assign dv_u = {r_slices, 1'b0};
    assign dv_v = {r_stacks, 1'b0};

    always_comb begin
        div_d[0].pt.st = i_stack_index;
        div_d[0].pt.sl = i_slice_index;
        div_d[0].ru    = {1'b0, i_slice_index, 17'd0} + {18'd0, r_slices};
        div_d[0].rv    = {1'b0, i_stack_index, 17'd0} + {18'd0, r_stacks};
        div_d[0].rp    = {2'b0, i_stack_index, 16'd0} + {18'd0, r_stacks};
        div_d[0].qu    = 17'd0;
        div_d[0].qv    = 17'd0;
        div_d[0].qp    = 17'd0;
    end
    assign div_v[0]   = i_in_valid;
    assign o_in_stall = !div_en[0];

    for (genvar k = 0; k < usg_pkg::DIV_STEPS; k++) begin : g_div
        logic down_en;
        if (k == usg_pkg::DIV_STEPS - 1) begin : g_last
            assign down_en = prep_en;
        end else begin : g_mid
            assign down_en = div_en[k+1];
        end
        usg_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (5'(usg_pkg::DIV_STEPS - 1 - k)),
            .i_dv_u    (dv_u),
            .i_dv_v    (dv_v),
            .i_valid   (div_v[k]),
            .i_d       (div_d[k]),
            .i_down_en (down_en),
            .o_en      (div_en[k]),
            .o_valid   (div_v[k+1]),
            .o_d       (div_d[k+1])
        );
    end

    // Phase stage: split each 16-bit phase into quadrant and an angle
    // within the quadrant, scaled to Q30 radians.
    usg_pkg::t_cor cor_d [0:usg_pkg::CORDIC_STEPS];
    logic          cor_v [0:usg_pkg::CORDIC_STEPS];
    logic          cor_en [0:usg_pkg::CORDIC_STEPS-1];
    logic          post_en;
    logic          r_prep_v;
    usg_pkg::t_cor r_prep;
    usg_pkg::t_cor n_prep;
    logic [15:0]   pha, php;
    logic [44:0]   za_w, zp_w;

    assign prep_en = !r_prep_v || cor_en[0];

    always_comb begin
        pha         = div_d[usg_pkg::DIV_STEPS].qu[15:0];
        php         = div_d[usg_pkg::DIV_STEPS].qp[15:0];
        za_w        = pha[13:0] * usg_pkg::HALF_PI_Q30;
        zp_w        = php[13:0] * usg_pkg::HALF_PI_Q30;
        n_prep.pt   = div_d[usg_pkg::DIV_STEPS].pt;
        n_prep.qu   = div_d[usg_pkg::DIV_STEPS].qu;
        n_prep.qv   = div_d[usg_pkg::DIV_STEPS].qv;
        n_prep.qa   = pha[15:14];
        n_prep.qp   = php[15:14];
        n_prep.xa   = usg_pkg::CORDIC_GAIN;
        n_prep.ya   = 33'sd0;
        n_prep.za   = $signed({2'b0, za_w[44:14]});
        n_prep.xp   = usg_pkg::CORDIC_GAIN;
        n_prep.yp   = 33'sd0;
        n_prep.zp   = $signed({2'b0, zp_w[44:14]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_v <= 1'b0;
        end else if (prep_en) begin
            r_prep_v <= div_v[usg_pkg::DIV_STEPS];
        end
        if (prep_en) begin
            r_prep <= n_prep;
        end
    end

    assign cor_d[0] = r_prep;
    assign cor_v[0] = r_prep_v;

    // CORDIC chain: both angles rotate side by side, one step per cell.
    for (genvar k = 0; k < usg_pkg::CORDIC_STEPS; k++) begin : g_cor
        logic down_en;
        if (k == usg_pkg::CORDIC_STEPS - 1) begin : g_last
            assign down_en = post_en;
        end else begin : g_mid
            assign down_en = cor_en[k+1];
        end
        usg_cordic_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_step    (5'(k)),
            .i_valid   (cor_v[k]),
            .i_d       (cor_d[k]),
            .i_down_en (down_en),
            .o_en      (cor_en[k]),
            .o_valid   (cor_v[k+1]),
            .o_d       (cor_d[k+1])
        );
    end

    // Output side: products, rounding, off-grid masking, output register.
    usg_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_slices      (r_slices),
        .i_stacks      (r_stacks),
        .i_radius      (r_radius),
        .i_valid       (cor_v[usg_pkg::CORDIC_STEPS]),
        .i_d           (cor_d[usg_pkg::CORDIC_STEPS]),
        .i_out_stall   (i_out_stall),
        .o_en          (post_en),
        .o_out_valid   (o_out_valid),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_norm_x      (o_norm_x),
        .o_norm_y      (o_norm_y),
        .o_norm_z      (o_norm_z),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_quad_first  (o_quad_first),
        .o_quad_second (o_quad_second),
        .o_quad_valid  (o_quad_valid),
        .o_point_valid (o_point_valid)
    );

    // A quad only exists on a valid grid point.
    `USG_ASSERT(a_quad_on_grid, !(o_out_valid && o_quad_valid && !o_point_valid), "quad off grid")
    // Off-grid items carry zero payload (checked on tex_u and pos_y).
    `USG_ASSERT(a_off_zero, !(o_out_valid && !o_point_valid && (o_tex_u != 17'd0 || o_pos_y != 17'sd0)), "off-grid payload not zero")
    // Texture coordinate never exceeds 1.0.
    `USG_ASSERT(a_tex_range, !(o_out_valid && (o_tex_u > 17'd65536 || o_tex_v > 17'd65536)), "texture out of range")
    // A radius write lands in the register.
    `USG_ASSERT_NEXT(a_cfg_radius, i_cfg_we && i_cfg_idx == usg_pkg::REG_RADIUS, r_radius == $past(i_cfg_data), "radius write lost")
endmodule
